[rtl/core/dmrb_pkg.sv]
// ----------------------------------------------------------------------------
// dmrb_pkg
// Shared types and codes of the delimited message ring buffer.
// ----------------------------------------------------------------------------
package dmrb_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam logic [7:0] DELIM_RESET = 8'd35;   // '#'

	// pending count follows plain 32-bit arithmetic: after the delimiter changes,
	// closed messages can outnumber the bytes held in the store
	localparam int PEND_W = 32;

	// input kinds, as they arrive on the slave tuser
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// result status, as it leaves on the master tuser
	localparam logic [2:0] STAT_BYTE   = 3'd0;
	localparam logic [2:0] STAT_ACCEPT = 3'd1;
	localparam logic [2:0] STAT_DROP   = 3'd2;
	localparam logic [2:0] STAT_NONE   = 3'd3;
	localparam logic [2:0] STAT_EMPTY  = 3'd4;

	// classified commands handed from front to back
	typedef enum logic [1:0] {
		OP_WRITE,
		OP_DROP,
		OP_CLOSE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

endpackage

[rtl/core/dmrb_front.sv]
// ----------------------------------------------------------------------------
// dmrb_front
// Takes input words, classifies them and registers the command for the queue.
// ----------------------------------------------------------------------------
module dmrb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        delim,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_kind,
	input  logic [7:0]        in_data,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output dmrb_pkg::cmd_t    cmd
);
	import dmrb_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_class;
	logic keep;

	always_comb begin
		cmd_class.data = in_data;
		cmd_class.op   = OP_DROP;
		keep           = 1'b1;
		case (in_kind)
			KIND_WRITE: begin
				// a data byte equal to the delimiter would split the message
				cmd_class.op = (in_data == delim) ? OP_DROP : OP_WRITE;
			end
			KIND_CLOSE: cmd_class.op = OP_CLOSE;
			KIND_READ:  cmd_class.op = OP_READ;
			default:    keep = 1'b0;   // unused kind: no result at all
		endcase
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_class;
		end
	end

endmodule

[rtl/core/dmrb_queue.sv]
// ----------------------------------------------------------------------------
// dmrb_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module dmrb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              in_ready,
	input  dmrb_pkg::cmd_t    in_cmd,
	output logic              out_valid,
	input  logic              pop,
	output dmrb_pkg::cmd_t    out_cmd
);
	import dmrb_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign do_push   = push && in_ready;
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

[rtl/core/dmrb_back.sv]
// ----------------------------------------------------------------------------
// dmrb_back
// Ring store, pointers and counters; carries out commands, registers results.
// ----------------------------------------------------------------------------
module dmrb_back #(
	parameter int DEPTH = dmrb_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        delim,
	input  logic              cmd_valid,
	input  dmrb_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [7:0]        res_data,
	output logic [2:0]        res_status,
	output logic              res_last
);
	import dmrb_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HEAD = 2'd1;   // first byte of the message on mem_q
	localparam logic [1:0] S_BODY = 2'd2;   // cur_q to send, next byte on mem_q

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
		adv = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	logic [7:0]        mem [DEPTH];
	logic [7:0]        mem_q;

	logic [1:0]        state_q, state_d;
	logic [PW-1:0]     wp_q, wp_d;
	logic [PW-1:0]     rp_q, rp_d;
	logic [FW-1:0]     fill_q, fill_d;
	logic [PEND_W-1:0] pend_q, pend_d;
	logic [7:0]        cur_q, cur_d;

	logic              out_free;
	logic              emit;
	logic [7:0]        emit_data;
	logic [2:0]        emit_status;
	logic              emit_last;
	logic              mem_we;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [PW-1:0]     mem_raddr;
	logic              more;
	logic              body_last;

	assign out_free  = !res_valid || res_ready;
	assign more      = (fill_q != FW'(1));
	assign body_last = !more || (mem_q == delim);

	always_comb begin
		state_d     = state_q;
		wp_d        = wp_q;
		rp_d        = rp_q;
		fill_d      = fill_q;
		pend_d      = pend_q;
		cur_d       = cur_q;
		cmd_pop     = 1'b0;
		emit        = 1'b0;
		emit_data   = 8'd0;
		emit_status = STAT_ACCEPT;
		emit_last   = 1'b1;
		mem_we      = 1'b0;
		mem_wdata   = cmd.data;
		mem_re      = 1'b0;
		mem_raddr   = rp_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_WRITE: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								emit    = 1'b1;
								// keep one slot free for the closing delimiter
								if (fill_q >= FW'(DEPTH - 1)) begin
									emit_status = STAT_DROP;
								end else begin
									mem_we = 1'b1;
									wp_d   = adv(wp_q);
									fill_d = fill_q + FW'(1);
								end
							end
						end
						OP_CLOSE: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								emit    = 1'b1;
								if (fill_q == FW'(DEPTH)) begin
									emit_status = STAT_DROP;
								end else begin
									mem_we    = 1'b1;
									mem_wdata = delim;
									wp_d      = adv(wp_q);
									fill_d    = fill_q + FW'(1);
									pend_d    = pend_q + PEND_W'(1);
								end
							end
						end
						OP_READ: begin
							if (pend_q == '0) begin
								if (out_free) begin
									cmd_pop     = 1'b1;
									emit        = 1'b1;
									emit_status = STAT_NONE;
								end
							end else if (fill_q == '0) begin
								if (out_free) begin
									cmd_pop     = 1'b1;
									emit        = 1'b1;
									emit_status = STAT_EMPTY;
									pend_d      = pend_q - PEND_W'(1);
								end
							end else begin
								cmd_pop = 1'b1;
								pend_d  = pend_q - PEND_W'(1);
								mem_re  = 1'b1;
								state_d = S_HEAD;
							end
						end
						default: begin
							if (out_free) begin
								cmd_pop     = 1'b1;
								emit        = 1'b1;
								emit_status = STAT_DROP;
							end
						end
					endcase
				end
			end
			S_HEAD: begin
				if (mem_q == delim) begin
					// empty message: consume just the delimiter
					if (out_free) begin
						emit        = 1'b1;
						emit_status = STAT_EMPTY;
						rp_d        = adv(rp_q);
						fill_d      = fill_q - FW'(1);
						state_d     = S_IDLE;
					end
				end else begin
					cur_d     = mem_q;
					mem_re    = 1'b1;
					mem_raddr = adv(rp_q);
					state_d   = S_BODY;
				end
			end
			S_BODY: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_data   = cur_q;
					emit_status = STAT_BYTE;
					emit_last   = body_last;
					if (body_last) begin
						state_d = S_IDLE;
						if (more) begin
							// drop the delimiter along with the final byte
							rp_d   = adv(adv(rp_q));
							fill_d = fill_q - FW'(2);
						end else begin
							rp_d   = adv(rp_q);
							fill_d = fill_q - FW'(1);
						end
					end else begin
						rp_d      = adv(rp_q);
						fill_d    = fill_q - FW'(1);
						cur_d     = mem_q;
						mem_re    = 1'b1;
						mem_raddr = adv(adv(rp_q));
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wp_q      <= '0;
			rp_q      <= '0;
			fill_q    <= '0;
			pend_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			fill_q  <= fill_d;
			pend_q  <= pend_d;
			if (emit) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (emit) begin
			res_data   <= emit_data;
			res_status <= emit_status;
			res_last   <= emit_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= mem_wdata;
		end
		if (mem_re) begin
			mem_q <= mem[mem_raddr];
		end
	end

endmodule

[rtl/core/delimited_message_ring_buffer.sv]
// ----------------------------------------------------------------------------
// delimited_message_ring_buffer
// Byte ring store of delimiter-terminated messages with a stream interface.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser[1:0] = kind (0 write byte, 1 close message, 2 read
//   oldest message, 3 ignored), tdata[7:0] = data byte.
//   Master stream: tdata[7:0] = message byte (0 unless status is byte),
//   tuser[2:0] = status, tlast = final result word of the input word.
//   cfg_we/cfg_wdata load the delimiter; write it only while the block is idle.
// Path: a write or close passes the input register, command queue and result
//   register before its one word shows. A read answers in the idle state
//   (nothing pending, or store empty), the head state (empty message) or the
//   body state (message bytes), then streams one message byte per cycle.
// Throughput, while the receiver takes every word: one input word per cycle
//   for writes and closes, one result word per cycle. A read holds the back
//   end in head and body states (each byte read ahead, to find the last one).
// A two-entry command queue sits between the input stage and the back end,
//   and the result word sits in an output register: a stalled receiver holds
//   that word, the queue fills and only then tready drops.
// Reset clears pointers, counts and the delimiter (back to '#'); the store
//   contents are not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module delimited_message_ring_buffer #(
	parameter int DEPTH = dmrb_pkg::DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,         // delimiter byte
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,      // [7:0] data_in
	input  logic [1:0] s_axis_tuser,      // [1:0] kind
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,      // [7:0] data_out
	output logic [2:0] m_axis_tuser,      // [2:0] status
	output logic       m_axis_tlast
);
	import dmrb_pkg::*;

	logic [7:0] delim_q;

	// front stage to queue
	logic       f_valid;
	logic       f_ready;
	cmd_t       f_cmd;

	// queue to back end
	logic       q_valid;
	logic       q_pop;
	cmd_t       q_cmd;

	// delimiter register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_we) begin
			delim_q <= cfg_wdata;
		end
	end

	// input classification; drops data bytes that equal the delimiter
	dmrb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.delim     (delim_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	dmrb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (q_valid),
		.pop       (q_pop),
		.out_cmd   (q_cmd)
	);

	// store, counters and result register
	dmrb_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.delim      (delim_q),
		.cmd_valid  (q_valid),
		.cmd        (q_cmd),
		.cmd_pop    (q_pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_data   (m_axis_tdata),
		.res_status (m_axis_tuser),
		.res_last   (m_axis_tlast)
	);

	// only message bytes carry data
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != STAT_BYTE)) |-> (m_axis_tdata == 8'd0))
		else $error("non-byte result carries data");

	// every non-byte result is the only result of its word
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != STAT_BYTE)) |-> m_axis_tlast)
		else $error("non-byte result without last");

	// the queue never takes a command it has no room for
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && !f_ready) |=> f_valid)
		else $error("command lost between front and queue");

endmodule

[tb/dmrb_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dmrb_scoreboard_pkg
// Message store predictor and result word checker for the ring buffer test.
// ----------------------------------------------------------------------------
package dmrb_scoreboard_pkg;
	import dmrb_pkg::*;

	// kind code the block ignores; no word comes back for it
	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [7:0] data;
		logic [2:0] status;
		logic       last;
	} result_t;

	class message_store_sb;
		logic [7:0]        mem [DEPTH_DEFAULT];
		int unsigned       wr_ptr;
		int unsigned       rd_ptr;
		int unsigned       fill;
		logic [PEND_W-1:0] pend;
		logic [7:0]        delim;
		result_t           due [$];
		int                failures;

		function new();
			wr_ptr   = 0;
			rd_ptr   = 0;
			fill     = 0;
			pend     = '0;
			delim    = DELIM_RESET;
			failures = 0;
		endfunction

		function void set_delim(logic [7:0] value);
			delim = value;
		endfunction

		function int unsigned outstanding();
			return due.size();
		endfunction

		function logic [PEND_W-1:0] pending_count();
			return pend;
		endfunction

		function int unsigned next_slot(int unsigned p);
			return (p + 1 == DEPTH_DEFAULT) ? 0 : p + 1;
		endfunction

		function void queue_result(logic [7:0] data, logic [2:0] status, logic last);
			result_t r;
			r.data   = data;
			r.status = status;
			r.last   = last;
			due.push_back(r);
		endfunction

		function void put_byte(logic [7:0] b);
			mem[wr_ptr] = b;
			wr_ptr = next_slot(wr_ptr);
			fill++;
		endfunction

		// predict the words caused by one accepted input word
		function void note_input(logic [1:0] kind, logic [7:0] data);
			int unsigned n;
			int unsigned p;
			bit          found;
			n     = 0;
			p     = rd_ptr;
			found = 1'b0;
			case (kind)
				KIND_WRITE: begin
					// last slot is kept for a delimiter
					if (data == delim || fill + 1 >= DEPTH_DEFAULT) begin
						queue_result(8'd0, STAT_DROP, 1'b1);
					end else begin
						put_byte(data);
						queue_result(8'd0, STAT_ACCEPT, 1'b1);
					end
				end
				KIND_CLOSE: begin
					if (fill >= DEPTH_DEFAULT) begin
						queue_result(8'd0, STAT_DROP, 1'b1);
					end else begin
						put_byte(delim);
						pend++;
						queue_result(8'd0, STAT_ACCEPT, 1'b1);
					end
				end
				KIND_READ: begin
					if (pend == 0) begin
						queue_result(8'd0, STAT_NONE, 1'b1);
					end else begin
						pend--;
						// scan for the current delimiter among stored bytes
						while (n < fill && !found) begin
							if (mem[p] == delim) begin
								found = 1'b1;
							end else begin
								n++;
								p = next_slot(p);
							end
						end
						if (n == 0) begin
							if (found) begin
								rd_ptr = next_slot(rd_ptr);
								fill--;
							end
							queue_result(8'd0, STAT_EMPTY, 1'b1);
						end else begin
							p = rd_ptr;
							for (int k = 0; k < n; k++) begin
								queue_result(mem[p], STAT_BYTE, k + 1 == n);
								p = next_slot(p);
							end
							if (found) begin
								p = next_slot(p);
								fill -= n + 1;
							end else begin
								fill -= n;
							end
							rd_ptr = p;
						end
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void fail_note(string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_result(logic [7:0] d, logic [2:0] s, logic l);
			result_t want;
			if (due.size() == 0) begin
				fail_note($sformatf("stray word: data=%02h status=%0d last=%0b", d, s, l));
			end else begin
				want = due.pop_front();
				if (want.data !== d || want.status !== s || want.last !== l)
					fail_note($sformatf({"word mismatch: expected data=%02h status=%0d last=%0b,",
						" got data=%02h status=%0d last=%0b"},
						want.data, want.status, want.last, d, s, l));
			end
		endfunction
	endclass

endpackage

[tb/delimited_message_ring_buffer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delimited_message_ring_buffer_test
// Drives byte writes, message closes and reads into the ring buffer, predicts
// every result word with a scoreboard copy of the store, and checks each word
// as it leaves. Runs directed corner cases, random message traffic under
// several delimiter settings, a store fill under a long receiver hold-off and
// random idling on both stream sides.
// ----------------------------------------------------------------------------
module delimited_message_ring_buffer_test;
	import dmrb_pkg::*;
	import dmrb_scoreboard_pkg::*;

	// margin for the pipe to settle after the last predicted word, also covering the ignored kind
	localparam int SETTLE_CYCLES   = 12;
	localparam int DRAIN_LIMIT     = 200000;
	localparam int HOLD_OFF_CYCLES = 300;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       cfg_we        = 1'b0;
	logic [7:0] cfg_wdata     = DELIM_RESET;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;   // [7:0] data_in
	logic [1:0] s_axis_tuser  = 2'd0;   // [1:0] kind
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] data_out
	logic [2:0] m_axis_tuser;           // [2:0] status
	logic       m_axis_tlast;

	message_store_sb sb;
	bit              idle_on  = 1'b1;   // random idling on both sides
	int unsigned     hold_req = 0;      // receiver hold-off request, in cycles

	delimited_message_ring_buffer #(
		.DEPTH(DEPTH_DEFAULT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#(8_000_000);
		$display("delimited_message_ring_buffer_test: done, errors");
		$finish;
	end

	// Receiver: checks each accepted word, then picks tready for the next edge.
	// A hold-off request keeps tready low for that many cycles.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= !(idle_on && $urandom_range(99) < 6);
			end
		end
	end

	// Offer one word, with a random gap first; returns at the accepting edge.
	// tvalid stays high on return so back-to-back words need no re-raise.
	task automatic send_word(input logic [1:0] kind, input logic [7:0] data);
		while (idle_on && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(kind, data);
	endtask

	// Stop offering, wait for every predicted word, then let the pipe settle.
	task automatic wait_idle();
		int unsigned n;
		n = 0;
		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Delimiter load; only called with the block idle.
	task automatic write_delim(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_delim(value);
	endtask

	task automatic send_message(input int len);
		repeat (len) send_word(KIND_WRITE, 8'($urandom_range(255)));
		send_word(KIND_CLOSE, 8'($urandom_range(255)));
	endtask

	task automatic flush_pending();
		while (sb.pending_count() != 0)
			send_word(KIND_READ, 8'($urandom_range(255)));
	endtask

	// Mostly well-formed messages (usually short, now and then long) each
	// followed by a read most of the time; the rest is loose reads, stray
	// writes and closes, and ignored words that do not count.
	task automatic random_traffic(input int items);
		int count;
		int len;
		int pick;
		count = 0;
		while (count < items) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
				send_message(len);
				count += len + 1;
				if ($urandom_range(99) < 75) begin
					send_word(KIND_READ, 8'($urandom_range(255)));
					count++;
				end
			end else if (pick < 86) begin
				send_word(KIND_READ, 8'($urandom_range(255)));
				count++;
			end else if (pick < 95) begin
				send_word($urandom_range(1) ? KIND_CLOSE : KIND_WRITE,
					8'($urandom_range(255)));
				count++;
			end else begin
				send_word(KIND_IGNORED, 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_delim(DELIM_RESET);
		@(posedge clk);

		// --- directed corner cases ---
		send_word(KIND_READ, 8'h00);          // nothing pending
		send_word(KIND_CLOSE, 8'hFF);
		send_word(KIND_READ, 8'hFF);          // empty message
		send_word(KIND_WRITE, 8'h00);
		send_word(KIND_WRITE, 8'hFF);
		send_word(KIND_WRITE, DELIM_RESET);   // data equal to delimiter: dropped
		send_word(KIND_WRITE, 8'hA5);
		send_word(KIND_IGNORED, 8'h5A);       // no word back
		send_word(KIND_CLOSE, 8'h00);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_WRITE, 8'h01);
		send_word(KIND_CLOSE, 8'h00);
		send_word(KIND_WRITE, 8'h02);
		send_word(KIND_WRITE, 8'h03);
		send_word(KIND_CLOSE, 8'h00);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_READ, 8'h00);          // nothing pending again
		wait_idle();

		// --- random traffic, default delimiter ---
		random_traffic(40);

		// --- fill the store while the receiver holds off ---
		// input stalls once the command queue backs up; writes past the last data
		// slot drop, the close takes the last slot, a second close finds it full
		flush_pending();
		hold_req = HOLD_OFF_CYCLES;
		repeat (70) send_word(KIND_WRITE, 8'($urandom_range(255)));
		send_word(KIND_CLOSE, 8'h00);
		send_word(KIND_CLOSE, 8'h00);
		flush_pending();
		wait_idle();

		// --- delimiter change with messages stored under the old one ---
		// read runs off the end of the store, then finds it empty
		send_message(5);
		send_message(2);
		wait_idle();
		write_delim(8'h00);
		@(posedge clk);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_READ, 8'h00);

		// --- delimiter 0, no idling on either side ---
		idle_on = 1'b0;
		random_traffic(30);
		wait_idle();
		idle_on = 1'b1;

		// --- delimiter 255 ---
		write_delim(8'hFF);
		@(posedge clk);
		random_traffic(30);
		wait_idle();

		// --- random delimiter ---
		write_delim(8'($urandom_range(255)));
		@(posedge clk);
		random_traffic(25);

		wait_idle();
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("delimited_message_ring_buffer_test: done, clean");
		else
			$display("delimited_message_ring_buffer_test: done, errors");
		$finish;
	end

endmodule
